### rtl/preemptive_priority_scheduler_defines.svh
// Assertion macros used by the top-level scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Check a same-cycle implication on the rising clock edge, idle in reset.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Check an implication that lands in the next cycle, idle in reset.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

### rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

    // Table size and derived index width
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Fixed field widths
    localparam int IN_SLOT_W = 3;
    localparam int DUR_W     = 16;
    localparam int PRI_W     = 8;
    localparam int TICK_W    = 16;
    localparam int MASK_W    = 8;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic load_write;
        logic scan_step;
        logic fetch;
        logic update;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/pps_ctrl.sv
`default_nettype none

module pps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               mode,
    input  wire pps_pkg::dp_status_t status,
    output pps_pkg::dp_cmd_t        cmd,
    output logic                    busy,
    output logic                    done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_LAST,
        ST_FETCH,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Decode next state and the result strobe
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mode ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.capture    = (state_reg == ST_IDLE) && start;
        cmd.load_write = (state_reg == ST_LOAD);
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.fetch      = (state_reg == ST_FETCH);
        cmd.update     = (state_reg == ST_UPDATE);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/pps_datapath.sv
`default_nettype none

module pps_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pps_pkg::dp_cmd_t              cmd,
    output pps_pkg::dp_status_t                status,
    input  wire logic [pps_pkg::IN_SLOT_W-1:0] slot,
    input  wire logic [pps_pkg::DUR_W-1:0]     load_duration,
    input  wire logic [pps_pkg::PRI_W-1:0]     load_priority,
    input  wire logic [pps_pkg::TICK_W-1:0]    load_arrival,
    output logic                               run_valid,
    output logic [pps_pkg::IN_SLOT_W-1:0]      run_slot,
    output logic                               run_finished,
    output logic [pps_pkg::MASK_W-1:0]         waiting_mask,
    output logic                               all_done,
    output logic [pps_pkg::TICK_W-1:0]         tick_time
);

    localparam int SLOTS  = pps_pkg::SLOTS;
    localparam int SLOT_W = pps_pkg::SLOT_W;
    localparam int MASK_W = pps_pkg::MASK_W;

    // Process table memories
    logic [pps_pkg::DUR_W-1:0]  rem_mem [SLOTS];
    logic [pps_pkg::PRI_W-1:0]  pri_mem [SLOTS];
    logic [pps_pkg::TICK_W-1:0] arr_mem [SLOTS];

    // Captured item
    logic [pps_pkg::IN_SLOT_W-1:0] slot_in_reg;
    logic [pps_pkg::DUR_W-1:0]     dur_in_reg;
    logic [pps_pkg::PRI_W-1:0]     pri_in_reg;
    logic [pps_pkg::TICK_W-1:0]    arr_in_reg;

    // Scan state
    logic [SLOT_W-1:0]          scan_idx_reg;
    logic [SLOT_W-1:0]          cmp_idx_reg;
    logic                       cmp_valid_reg;
    logic [pps_pkg::PRI_W-1:0]  pri_rd_reg;
    logic [pps_pkg::TICK_W-1:0] arr_rd_reg;
    logic [pps_pkg::DUR_W-1:0]  rem_rd_reg;
    logic                       found_reg;
    logic [SLOT_W-1:0]          best_reg;
    logic [pps_pkg::PRI_W-1:0]  best_pri_reg;
    logic [SLOTS-1:0]           ready_mask_reg;

    // Architectural state
    logic [SLOTS-1:0]           active_reg;
    logic [SLOTS-1:0]           active_next;
    logic [pps_pkg::TICK_W-1:0] tick_reg;

    // Result registers
    logic                          run_valid_reg;
    logic [pps_pkg::IN_SLOT_W-1:0] run_slot_reg;
    logic                          run_finished_reg;
    logic [MASK_W-1:0]             waiting_mask_reg;
    logic                          all_done_reg;
    logic [pps_pkg::TICK_W-1:0]    tick_time_reg;

    logic                          load_in_range;
    logic [SLOT_W-1:0]             load_addr;
    logic                          ready;
    logic                          take;
    logic [pps_pkg::DUR_W-1:0]     rem_dec;
    logic                          run_finish;
    logic [SLOTS-1:0]              best_onehot;
    logic [SLOTS-1:0]              waiting_full;
    logic [SLOTS+MASK_W-1:0]       waiting_pad;
    logic                          rem_we;
    logic [SLOT_W-1:0]             rem_waddr;
    logic [pps_pkg::DUR_W-1:0]     rem_wdata;

    assign status.scan_last = (scan_idx_reg == SLOT_W'(SLOTS - 1));

    // Compare the slot read in the previous cycle against the best so far
    assign ready = cmp_valid_reg && active_reg[cmp_idx_reg] && (arr_rd_reg <= tick_reg);
    assign take  = ready && (!found_reg || (pri_rd_reg > best_pri_reg));

    // Decode load target and the decrement of the chosen slot
    assign load_in_range = ({4'b0, slot_in_reg} < 7'(SLOTS));
    assign load_addr     = SLOT_W'(slot_in_reg);
    assign rem_dec       = (rem_rd_reg == '0) ? rem_rd_reg : (rem_rd_reg - 1'b1);
    assign run_finish    = found_reg && (rem_dec == '0);
    assign best_onehot   = {{(SLOTS - 1){1'b0}}, 1'b1} << best_reg;
    assign waiting_full  = ready_mask_reg & ~(found_reg ? best_onehot : '0);
    assign waiting_pad   = {{MASK_W{1'b0}}, waiting_full};

    // Work out the active flags after this item
    always_comb
    begin
        active_next = active_reg;
        if (cmd.load_write && load_in_range)
        begin
            active_next[load_addr] = (dur_in_reg != '0);
        end
        else if (cmd.update && run_finish)
        begin
            active_next = active_reg & ~best_onehot;
        end
    end

    // Select the remaining-time write port
    always_comb
    begin
        rem_we    = (cmd.load_write && load_in_range) || (cmd.update && found_reg);
        rem_waddr = cmd.load_write ? load_addr : best_reg;
        rem_wdata = cmd.load_write ? dur_in_reg : rem_dec;
    end

    // Write and read the table memories
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (cmd.load_write && load_in_range)
        begin
            pri_mem[load_addr] <= pri_in_reg;
            arr_mem[load_addr] <= arr_in_reg;
        end
        if (cmd.scan_step)
        begin
            pri_rd_reg <= pri_mem[scan_idx_reg];
            arr_rd_reg <= arr_mem[scan_idx_reg];
        end
        if (cmd.fetch)
        begin
            rem_rd_reg <= rem_mem[best_reg];
        end
    end

    // Capture the item and track the best candidate
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_in_reg    <= slot;
            dur_in_reg     <= load_duration;
            pri_in_reg     <= load_priority;
            arr_in_reg     <= load_arrival;
            ready_mask_reg <= '0;
        end
        else if (cmp_valid_reg)
        begin
            ready_mask_reg[cmp_idx_reg] <= ready;
        end
        if (cmd.scan_step)
        begin
            cmp_idx_reg <= scan_idx_reg;
        end
        if (take)
        begin
            best_reg     <= cmp_idx_reg;
            best_pri_reg <= pri_rd_reg;
        end
    end

    // Advance scan control, active flags and time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            active_reg    <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            active_reg <= active_next;
            if (cmd.load_write)
            begin
                tick_reg <= '0;
            end
            else if (cmd.update && (tick_reg != pps_pkg::TICK_MAX))
            begin
                tick_reg <= tick_reg + 1'b1;
            end
        end
    end

    // Hold the result of the finished item
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            run_valid_reg    <= 1'b0;
            run_slot_reg     <= '0;
            run_finished_reg <= 1'b0;
            waiting_mask_reg <= '0;
            all_done_reg     <= ~|active_next;
            tick_time_reg    <= '0;
        end
        else if (cmd.update)
        begin
            run_valid_reg    <= found_reg;
            run_slot_reg     <= found_reg ? pps_pkg::IN_SLOT_W'(best_reg) : '0;
            run_finished_reg <= run_finish;
            waiting_mask_reg <= waiting_pad[MASK_W-1:0];
            all_done_reg     <= ~|active_next;
            tick_time_reg    <= tick_reg;
        end
    end

    assign run_valid    = run_valid_reg;
    assign run_slot     = run_slot_reg;
    assign run_finished = run_finished_reg;
    assign waiting_mask = waiting_mask_reg;
    assign all_done     = all_done_reg;
    assign tick_time    = tick_time_reg;

endmodule

`default_nettype wire

### rtl/preemptive_priority_scheduler.sv
`default_nettype none
`include "preemptive_priority_scheduler_defines.svh"

// Preemptive priority scheduler over a table of SLOTS process slots. Raise start
// while busy is low to hand over one item: mode 0 loads a slot (and restarts time
// at tick 0), mode 1 runs one scheduling tick. Each item yields exactly one result,
// shown for a single cycle with done high; there is no way to stall it, so capture
// it in that cycle. A load writes the slot in the load state. A tick steps through
// the scan, last, fetch and update states: the candidates are scanned one
// slot per cycle through the registered read port of the priority and arrival
// tables, then the chosen slot's remaining time is read, decremented and written
// back. A new item may be started in the cycle that done is high.
module preemptive_priority_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          mode,
    input  wire logic [pps_pkg::IN_SLOT_W-1:0] slot,
    input  wire logic [pps_pkg::DUR_W-1:0]     load_duration,
    input  wire logic [pps_pkg::PRI_W-1:0]     load_priority,
    input  wire logic [pps_pkg::TICK_W-1:0]    load_arrival,
    output logic                               done,
    output logic                               run_valid,
    output logic [pps_pkg::IN_SLOT_W-1:0]      run_slot,
    output logic                               run_finished,
    output logic [pps_pkg::MASK_W-1:0]         waiting_mask,
    output logic                               all_done,
    output logic [pps_pkg::TICK_W-1:0]         tick_time
);

    pps_pkg::dp_cmd_t    cmd;
    pps_pkg::dp_status_t status;

    // Sequence each item
    pps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the process table and compute results
    pps_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .slot          (slot),
        .load_duration (load_duration),
        .load_priority (load_priority),
        .load_arrival  (load_arrival),
        .run_valid     (run_valid),
        .run_slot      (run_slot),
        .run_finished  (run_finished),
        .waiting_mask  (waiting_mask),
        .all_done      (all_done),
        .tick_time     (tick_time)
    );

    // Check result timing and consistency
    `PPS_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `PPS_ASSERT_NOW(a_finish_ran, clk, rst_n, done && run_finished, run_valid)
    `PPS_ASSERT_NOW(a_last_finished, clk, rst_n, done && run_valid && all_done, run_finished)
    `PPS_ASSERT_NEXT(a_no_early_result, clk, rst_n, start && !busy, !done)

endmodule

`default_nettype wire
